// ===== src/sled_pkg.sv =====
// ----------------------------------------------------------------------------
// sled_pkg: shared types and constants for the status LED pulse encoder
// Field widths, register indexes, item kinds and the channel scaling helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sled_pkg;

  localparam int unsigned COLOR_BITS = 24;
  localparam int unsigned CNT_W      = $clog2(COLOR_BITS + 1);
  localparam int unsigned LEN_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]       LEVEL          = 8'd50;
  localparam logic [7:0]       BRIGHT_RST     = 8'd255;
  localparam logic [15:0]      INTERVAL_RST   = 16'd50;
  localparam logic [LEN_W-1:0] ONE_HIGH_RST   = 15'd14;
  localparam logic [LEN_W-1:0] ONE_LOW_RST    = 15'd6;
  localparam logic [LEN_W-1:0] ZERO_HIGH_RST  = 15'd6;
  localparam logic [LEN_W-1:0] ZERO_LOW_RST   = 15'd14;
  localparam logic [LEN_W-1:0] LATCH_RST      = 15'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgBrightness = 3'd0,
    CfgInterval   = 3'd1,
    CfgOneHigh    = 3'd2,
    CfgOneLow     = 3'd3,
    CfgZeroHigh   = 3'd4,
    CfgZeroLow    = 3'd5,
    CfgLatch      = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeTick     = 2'd0,
    ModeActivity = 2'd1,
    ModeLink     = 2'd2
  } mode_e;

  // Channel level times brightness over 255, truncated. The reciprocal form
  // (p + p/256 + 1) / 256 is exact for every p below 65280 in this 16-bit sum.
  function automatic logic [7:0] scale_level(logic [7:0] bright);
    logic [15:0] p;
    logic [15:0] q;
    p = 16'(bright) * 16'(LEVEL);
    q = (p + (p >> 8) + 16'd1) >> 8;
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/status_led_pixel_pulse_encoder_top.sv =====
// ----------------------------------------------------------------------------
// status_led_pixel_pulse_encoder_top: single-pixel status LED pulse encoder
// Turns ticks, activity events and link updates into one-wire pulse frames.
// ----------------------------------------------------------------------------
// Activity events and link updates only update flags; a tick whose wrapping
// distance from the last refresh is strictly above interval_ms latches a new
// colour word (green on pending activity, else blue if linked, else red) and
// starts a frame of 25 output beats: 24 data pulses MSB first in G,R,B order,
// then one low latch pulse with last_pulse set. The serializer sends one beat
// per cycle while the output side is ready. Input beats are held off only
// while a frame is still being sent, except in the cycle its last beat leaves,
// so the next frame can follow with no gap. Configuration is written through
// a plain write port and must be static while busy.
`default_nettype none

module status_led_pixel_pulse_encoder_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,

  input  wire logic                            cfg_we_i,
  input  wire logic [sled_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sled_pkg::CFG_DATA_W-1:0] cfg_data_i,

  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [31:0]                     now_ms_i,
  input  wire logic                            link_up_i,

  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic                            first_level_o,
  output      logic [sled_pkg::LEN_W-1:0]      first_len_o,
  output      logic                            second_level_o,
  output      logic [sled_pkg::LEN_W-1:0]      second_len_o,
  output      logic                            last_pulse_o
);

  localparam int unsigned LW = sled_pkg::LEN_W;
  localparam int unsigned CW = sled_pkg::CNT_W;
  localparam int unsigned NB = sled_pkg::COLOR_BITS;
  localparam logic [CW-1:0] LATCH_POS = CW'(NB);

  // Configuration registers
  logic [7:0]    bright_q;
  logic [15:0]   interval_q;
  logic [LW-1:0] one_high_q, one_low_q, zero_high_q, zero_low_q, latch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= sled_pkg::BRIGHT_RST;
      interval_q  <= sled_pkg::INTERVAL_RST;
      one_high_q  <= sled_pkg::ONE_HIGH_RST;
      one_low_q   <= sled_pkg::ONE_LOW_RST;
      zero_high_q <= sled_pkg::ZERO_HIGH_RST;
      zero_low_q  <= sled_pkg::ZERO_LOW_RST;
      latch_q     <= sled_pkg::LATCH_RST;
    end else if (cfg_we_i) begin
      unique case (sled_pkg::cfg_idx_e'(cfg_idx_i))
        sled_pkg::CfgBrightness: bright_q    <= cfg_data_i[7:0];
        sled_pkg::CfgInterval:   interval_q  <= cfg_data_i;
        sled_pkg::CfgOneHigh:    one_high_q  <= cfg_data_i[LW-1:0];
        sled_pkg::CfgOneLow:     one_low_q   <= cfg_data_i[LW-1:0];
        sled_pkg::CfgZeroHigh:   zero_high_q <= cfg_data_i[LW-1:0];
        sled_pkg::CfgZeroLow:    zero_low_q  <= cfg_data_i[LW-1:0];
        sled_pkg::CfgLatch:      latch_q     <= cfg_data_i[LW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Status state and frame serializer
  logic [31:0]   last_ms_q, last_ms_d;
  logic          pending_q, pending_d;
  logic          linked_q, linked_d;
  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NB-1:0] word_q, word_d;

  logic          in_fire, out_fire, frame_done, refresh;
  logic [31:0]   elapsed;
  logic [7:0]    lvl;
  logic          at_latch;

  assign at_latch   = (cnt_q == LATCH_POS);
  assign out_fire   = busy_q && out_ready_i;
  assign frame_done = out_fire && at_latch;
  assign in_ready_o = !busy_q || frame_done;
  assign in_fire    = in_valid_i && in_ready_o;

  assign elapsed = now_ms_i - last_ms_q;
  assign refresh = (sled_pkg::mode_e'(mode_i) == sled_pkg::ModeTick) &&
                   (elapsed > {16'd0, interval_q});
  assign lvl     = sled_pkg::scale_level(bright_q);

  always_comb begin
    last_ms_d = last_ms_q;
    pending_d = pending_q;
    linked_d  = linked_q;
    busy_d    = busy_q;
    cnt_d     = cnt_q;
    word_d    = word_q;

    // Advance the serializer on each beat taken downstream
    if (out_fire) begin
      if (at_latch) begin
        busy_d = 1'b0;
      end else begin
        cnt_d  = cnt_q + CW'(1);
        word_d = {word_q[NB-2:0], 1'b0};
      end
    end

    if (in_fire) begin
      unique case (sled_pkg::mode_e'(mode_i))
        sled_pkg::ModeActivity: pending_d = 1'b1;
        sled_pkg::ModeLink:     linked_d  = link_up_i;
        sled_pkg::ModeTick: begin
          if (refresh) begin
            last_ms_d = now_ms_i;
            busy_d    = 1'b1;
            cnt_d     = '0;
            priority if (pending_q) begin
              pending_d = 1'b0;
              word_d    = {lvl, 16'd0};
            end else if (linked_q) begin
              word_d    = {16'd0, lvl};
            end else begin
              word_d    = {8'd0, lvl, 8'd0};
            end
          end
        end
        default: ;  // unused mode: ignore the beat
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ms_q <= '0;
      pending_q <= 1'b0;
      linked_q  <= 1'b0;
      busy_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      last_ms_q <= last_ms_d;
      pending_q <= pending_d;
      linked_q  <= linked_d;
      busy_q    <= busy_d;
      cnt_q     <= cnt_d;
    end
  end

  // Color word needs no reset: it is only read while a frame is busy
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // Output beat: a data pulse from the word MSB, or the trailing latch pulse
  assign out_valid_o    = busy_q;
  assign first_level_o  = !at_latch;
  assign second_level_o = 1'b0;
  assign last_pulse_o   = at_latch;
  assign first_len_o    = at_latch ? latch_q :
                          (word_q[NB-1] ? one_high_q : zero_high_q);
  assign second_len_o   = at_latch ? '0 :
                          (word_q[NB-1] ? one_low_q : zero_low_q);

  // A new beat is never taken while a frame is mid-flight
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && busy_q |-> frame_done)
    else $error("input beat accepted during an unfinished frame");

  // A refreshing tick starts a frame at its first data pulse
  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && refresh |=> busy_q && cnt_q == '0)
    else $error("refresh tick did not start a frame");

  // A stalled frame holds its position
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !out_ready_i |=> busy_q && $stable(cnt_q))
    else $error("frame advanced without a downstream beat");

  // The frame ends once the latch pulse leaves and nothing restarts it
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done && !(in_fire && refresh) |=> !busy_q)
    else $error("frame did not end after the latch pulse");

endmodule

`default_nettype wire
